// ----- rtl/tpool_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpool_pkg: shared types and constants of the timer pool
// Holds the operation codes, the result kinds, the controller state type and
// the per-tick limit on timeout results.
// ----------------------------------------------------------------------------
package tpool_pkg;

  // Operation codes carried on the opcode port.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Kinds of result.
  localparam logic KIND_TIMEOUT = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  // Field widths fixed by the interface.
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned TARGET_W = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned ENTRY_W  = TARGET_W + COUNT_W;

  // At most this many timeout results leave one tick.
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/timer_pool_with_timeout_events.sv -----
`default_nettype none
// A start transaction to an in-range slot is written to the slot memory at its
// accept edge and busy stays low. A query result is registered in ST_QUERY. A
// tick holds busy through ST_SCAN, one slot memory read-modify-write per cycle,
// and ST_FLUSH, which releases the final held result. Timeout results appear one
// per expiry, each a strobe of one cycle; the receiver cannot stall. Reset clears
// the valid bit of every slot at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// timer_pool_with_timeout_events: pool of down-counting timers
// Slot counts and targets live in one synchronous memory. A tick walks the
// slots in index order, decrementing and writing back each nonzero count, and
// reports each slot that reaches zero. One expiry is held back so that the
// final result of a tick can carry the last flag.
// ----------------------------------------------------------------------------
module timer_pool_with_timeout_events #(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       opcode,
  input  wire logic [tpool_pkg::IDX_W-1:0]      timer_index,
  input  wire logic [tpool_pkg::TARGET_W-1:0]   event_target,
  input  wire logic [tpool_pkg::COUNT_W-1:0]    start_value,
  output logic                                  result_strobe,
  output logic                                  result_kind,
  output logic [tpool_pkg::TARGET_W-1:0]        event_target_res,
  output logic [tpool_pkg::IDX_W-1:0]           timer_index_res,
  output logic [tpool_pkg::COUNT_W-1:0]         count_value,
  output logic                                  last
);
  import tpool_pkg::*;

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Slot memory: {target, count} per slot, with a valid bit per slot.
  logic [ENTRY_W-1:0]    mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] valid;
  logic [ENTRY_W-1:0]    rd_data;
  logic                  rd_vld;

  state_t state, state_next;

  logic [AW-1:0]         scan_idx;
  logic [NRES_W-1:0]     nres;
  logic                  q_in_range;
  logic [IDX_W-1:0]      q_idx;

  // Held expiry, released when the next one is found or at the end of a tick.
  logic                  pend_vld;
  logic [TARGET_W-1:0]   pend_target;
  logic [IDX_W-1:0]      pend_idx;

  logic                  accept;
  logic [AW+IDX_W-1:0]   in_wide;
  logic [AW-1:0]         in_addr;
  logic                  in_range;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic [COUNT_W-1:0]    cur_cnt;
  logic [COUNT_W-1:0]    dec_cnt;
  logic                  expire;
  logic                  take;
  logic                  scan_last;
  logic [AW+IDX_W-1:0]   scan_wide;
  logic [IDX_W-1:0]      scan_idx3;

  // Input decode and address translation.
  always_comb begin
    accept    = start && !busy;
    in_wide   = {{AW{1'b0}}, timer_index};
    in_addr   = in_wide[AW-1:0];
    in_range  = 32'(timer_index) < NUM_TIMERS;
    scan_wide = {{IDX_W{1'b0}}, scan_idx};
    scan_idx3 = scan_wide[IDX_W-1:0];
    scan_last = scan_idx == AW'(NUM_TIMERS - 1);
  end

  // Entry under the scan: decrement and detect expiry.
  always_comb begin
    cur_cnt = rd_vld ? rd_data[COUNT_W-1:0] : '0;
    dec_cnt = cur_cnt - COUNT_W'(1);
    expire  = (state == ST_SCAN) && (cur_cnt == COUNT_W'(1));
    take    = expire && (nres < NRES_W'(MAX_RESULTS));
  end

  // Memory address and write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_idx;
    wr_data = {rd_data[ENTRY_W-1:COUNT_W], dec_cnt};
    if (state == ST_SCAN) begin
      rd_addr = scan_last ? '0 : scan_idx + AW'(1);
      wr_en   = cur_cnt != '0;
    end else begin
      rd_addr = (opcode == OP_QUERY) ? in_addr : '0;
      if (accept && opcode == OP_START && in_range) begin
        wr_en   = 1'b1;
        wr_addr = in_addr;
        wr_data = {event_target, start_value};
      end
    end
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Per-slot valid bits; an invalid slot reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  // Controller state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and busy.
  always_comb begin
    state_next = state;
    busy       = state != ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_QUERY) begin
            state_next = ST_QUERY;
          end else if (opcode == OP_TICK) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_QUERY: state_next = ST_IDLE;
      ST_SCAN:  state_next = scan_last ? ST_FLUSH : ST_SCAN;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Scan bookkeeping and held expiry.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
      nres     <= '0;
      scan_idx <= '0;
    end else begin
      if (state == ST_IDLE) begin
        pend_vld <= 1'b0;
        nres     <= '0;
        scan_idx <= '0;
      end else if (state == ST_SCAN) begin
        scan_idx <= scan_last ? '0 : scan_idx + AW'(1);
        if (take) begin
          pend_vld <= 1'b1;
          nres     <= nres + NRES_W'(1);
        end
      end else if (state == ST_FLUSH) begin
        pend_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_target <= rd_data[ENTRY_W-1:COUNT_W];
      pend_idx    <= scan_idx3;
    end
    if (accept) begin
      q_in_range <= in_range;
      q_idx      <= timer_index;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == ST_QUERY) || (pend_vld && state == ST_FLUSH) ||
                       (pend_vld && take);
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_QUERY) begin
      result_kind      <= KIND_QUERY;
      event_target_res <= (q_in_range && rd_vld) ? rd_data[ENTRY_W-1:COUNT_W] : '0;
      timer_index_res  <= q_idx;
      count_value      <= (q_in_range && rd_vld) ? rd_data[COUNT_W-1:0] : '0;
      last             <= 1'b1;
    end else begin
      result_kind      <= KIND_TIMEOUT;
      event_target_res <= pend_target;
      timer_index_res  <= pend_idx;
      count_value      <= '0;
      last             <= state == ST_FLUSH;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tpool_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpool_checker: port-level checks for the timer pool
// Watches the command and result ports and flags sequencing errors.
// ----------------------------------------------------------------------------
module tpool_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic [1:0]                     opcode,
  input wire logic                           result_strobe,
  input wire logic                           result_kind,
  input wire logic [tpool_pkg::COUNT_W-1:0]  count_value,
  input wire logic                           last
);
  import tpool_pkg::*;

  // A query answer is always the only result of its transaction.
  a_query_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result_kind == KIND_QUERY |-> last)
    else $error("query answer without last flag");

  // A timeout result always carries a zero count.
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result_kind == KIND_TIMEOUT |-> count_value == '0)
    else $error("timeout result with nonzero count");

  // An accepted query is always answered by a query result.
  a_query_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_QUERY |-> ##2 (result_strobe && result_kind == KIND_QUERY))
    else $error("query answer missing");

  // A start transaction never leaves a result behind it.
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_START |=> !result_strobe)
    else $error("result after start transaction");

  // A tick keeps the pool busy while the slots are scanned.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_TICK |=> busy)
    else $error("tick did not raise busy");

endmodule

bind timer_pool_with_timeout_events tpool_checker u_tpool_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .opcode        (opcode),
  .result_strobe (result_strobe),
  .result_kind   (result_kind),
  .count_value   (count_value),
  .last          (last)
);
`default_nettype wire
